// ===== design/scfl_pkg.sv =====
package scfl_pkg;

    localparam int LINK_W    = 12;
    localparam int BANK_W    = 3;
    localparam int REG_BANKS = 6;

    localparam logic [BANK_W-1:0] NO_BANK = 3'd6;

    // result action codes
    localparam logic [2:0] ACT_FRESH    = 3'd0;
    localparam logic [2:0] ACT_KEEP     = 3'd1;
    localparam logic [2:0] ACT_FREED    = 3'd2;
    localparam logic [2:0] ACT_FORWARD  = 3'd3;
    localparam logic [2:0] ACT_MOVED    = 3'd4;
    localparam logic [2:0] ACT_EXT_MOVE = 3'd5;

    // register indexes
    localparam logic [2:0] REG_BASE  = 3'd0;
    localparam logic [2:0] REG_COUNT = 3'd1;
    localparam logic [2:0] REG_BLK0  = 3'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LATCH,
        ST_SWEEP,
        ST_DEC,
        ST_POP,
        ST_PUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [BANK_W-1:0] nslot;
        logic [BANK_W-1:0] oslot;
        logic              up_found;
        logic [BANK_W-1:0] up_bank;
        logic              dn_found;
        logic [BANK_W-1:0] dn_bank;
    } t_dec;

endpackage

// ===== design/scfl_link_ram.sv =====
module scfl_link_ram #(
    parameter int DEPTH = 1536,
    parameter int AW    = 11,
    parameter int DW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== design/scfl_decode.sv =====
module scfl_decode #(
    parameter int NB = 6
) (
    input  logic [3:0]                  i_base,
    input  logic [scfl_pkg::BANK_W-1:0] i_count,
    input  logic [31:0]                 i_end [NB],
    input  logic [NB-1:0]               i_hvalid,
    input  logic [31:0]                 i_old_addr,
    input  logic [31:0]                 i_new_size,
    output scfl_pkg::t_dec              o_dec
);

    always_comb begin
        logic [scfl_pkg::BANK_W-1:0] ns;
        logic [scfl_pkg::BANK_W-1:0] os;
        logic                        uf;
        logic                        df;
        logic [scfl_pkg::BANK_W-1:0] ub;
        logic [scfl_pkg::BANK_W-1:0] db;
        ns = '0;
        os = '0;
        // size slot: count the block sizes the request exceeds
        for (int i = 0; i < NB; i++) begin
            if (i < int'(i_count) &&
                {1'b0, i_new_size} > (33'd1 << (5'(i_base) + 5'(i)))) begin
                ns = ns + 1'b1;
            end
            if (i + 1 < int'(i_count) && i_old_addr >= i_end[i]) begin
                os = os + 1'b1;
            end
        end
        // lowest bank with a free block in each search window
        uf = 1'b0;
        df = 1'b0;
        ub = '0;
        db = '0;
        for (int i = 0; i < NB; i++) begin
            if (!uf && i >= int'(ns) && i < int'(i_count) && i_hvalid[i]) begin
                uf = 1'b1;
                ub = scfl_pkg::BANK_W'(i);
            end
            if (!df && i >= int'(ns) && i < int'(os) && i_hvalid[i]) begin
                df = 1'b1;
                db = scfl_pkg::BANK_W'(i);
            end
        end
        o_dec.nslot    = ns;
        o_dec.oslot    = os;
        o_dec.up_found = uf;
        o_dec.up_bank  = ub;
        o_dec.dn_found = df;
        o_dec.dn_bank  = db;
    end

endmodule

// ===== design/size_class_free_list_allocator.sv =====
// Flow: an accepted word is decoded, then a link read on a pop, a link write on a push, and the
// result load; one word in flight, so a new word is taken only once the last result is loaded,
// later while a finished result waits for m_axis_tready.
// A reformat word sweeps the link memory one entry a cycle, a rate set by the single write
// port of the link memory.
// Reset: synchronous, active low; registers take their reset values, then the same sweep
// runs with s_axis_tready low and no result.
module size_class_free_list_allocator #(
    parameter int MAX_BANKS           = 6,
    parameter int MAX_BLOCKS_PER_BANK = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // old_addr [31:0], old_size [63:32], new_size [95:64]
    input  logic [95:0]  s_axis_tdata,
    // mode [0], old_external [1]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // block_addr [31:0], copy_len [63:32], bank [66:64], zero fill [71:67]
    output logic [71:0]  m_axis_tdata,
    // action [2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NB      = (MAX_BANKS < scfl_pkg::REG_BANKS) ? MAX_BANKS
                                                               : scfl_pkg::REG_BANKS;
    localparam int MPB     = MAX_BLOCKS_PER_BANK;
    localparam int IW      = (MPB > 1) ? $clog2(MPB) : 1;
    localparam int SBW     = (NB > 1) ? $clog2(NB) : 1;
    localparam int DEPTH   = NB * MPB;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW      = scfl_pkg::LINK_W + 1;
    localparam int BLK_MAX = (MPB < 256) ? MPB : 256;

    // configuration registers
    logic [3:0] r_cfg_base;
    logic [2:0] r_cfg_count;
    logic [8:0] r_cfg_blocks [scfl_pkg::REG_BANKS];

    // layout latched at the last reformat
    logic [3:0]                  r_lb;
    logic [scfl_pkg::BANK_W-1:0] r_lc;
    logic [8:0]                  r_lat_blk [NB];
    logic [31:0]                 r_start [NB];
    logic [31:0]                 r_end [NB];
    logic [31:0]                 r_pos;   // region end once the sweep is done

    // free list heads
    logic [scfl_pkg::LINK_W-1:0] r_head [NB];
    logic [NB-1:0]               r_hv;

    // control
    scfl_pkg::t_state r_state, n_state;
    logic             r_reply;
    logic [SBW-1:0]   r_sb;
    logic [IW-1:0]    r_sj;

    // captured word
    logic        r_old_ext;
    logic [31:0] r_old_addr;
    logic [31:0] r_old_size;
    logic [31:0] r_new_size;

    // pending result and operations
    logic [2:0]                  r_res_action;
    logic [31:0]                 r_res_addr;
    logic [31:0]                 r_res_len;
    logic [scfl_pkg::BANK_W-1:0] r_res_bank;
    logic                        r_do_push;
    logic [scfl_pkg::BANK_W-1:0] r_pop_bank;

    // output register
    logic                        r_out_valid;
    logic [2:0]                  r_out_action;
    logic [31:0]                 r_out_addr;
    logic [31:0]                 r_out_len;
    logic [scfl_pkg::BANK_W-1:0] r_out_bank;

    logic          w_in_acc;
    logic          w_cfg_wr;
    logic [2:0]    w_cfg_idx;
    logic          w_load_out;

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [DW-1:0] w_mem_wdata;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_raddr;
    logic [DW-1:0] w_mem_rdata;

    scfl_pkg::t_dec w_dec;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_cfg_idx)
            scfl_pkg::REG_BASE:  prdata = 32'(r_cfg_base);
            scfl_pkg::REG_COUNT: prdata = 32'(r_cfg_count);
            default:             prdata = 32'(r_cfg_blocks[3'(w_cfg_idx - scfl_pkg::REG_BLK0)]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= 4'd4;
            r_cfg_count <= 3'd6;
            for (int i = 0; i < scfl_pkg::REG_BANKS; i++) begin
                r_cfg_blocks[i] <= 9'd64;
            end
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                scfl_pkg::REG_BASE:  r_cfg_base  <= pwdata[3:0];
                scfl_pkg::REG_COUNT: r_cfg_count <= pwdata[2:0];
                default:             r_cfg_blocks[3'(w_cfg_idx - scfl_pkg::REG_BLK0)]
                                         <= pwdata[8:0];
            endcase
        end
    end

    // ---------------- layout latch values ----------------
    logic [3:0]                  w_lb;
    logic [scfl_pkg::BANK_W-1:0] w_lc;
    logic [8:0]                  w_blk [NB];

    always_comb begin
        w_lb = r_cfg_base;
        if (w_lb < 4'd3)  w_lb = 4'd3;
        if (w_lb > 4'd12) w_lb = 4'd12;
        w_lc = r_cfg_count;
        if (w_lc < 3'd1)                       w_lc = 3'd1;
        if (int'(w_lc) > NB)                   w_lc = scfl_pkg::BANK_W'(NB);
        for (int i = 0; i < NB; i++) begin
            w_blk[i] = r_cfg_blocks[i];
            if (w_blk[i] < 9'd1)               w_blk[i] = 9'd1;
            if (int'(w_blk[i]) > BLK_MAX)      w_blk[i] = 9'(BLK_MAX);
            if (i >= int'(w_lc))               w_blk[i] = 9'd0;
        end
    end

    // ---------------- sweep datapath ----------------
    logic [8:0]  w_sw_blk;
    logic [12:0] w_sw_j1;
    logic [31:0] w_sw_len;
    logic        w_sw_last_j;
    logic        w_sw_done;

    assign w_sw_blk    = r_lat_blk[r_sb];
    assign w_sw_j1     = 13'(r_sj) + 13'd1;
    assign w_sw_len    = 32'(w_sw_blk) << (5'(r_lb) + 5'(r_sb));
    assign w_sw_last_j = (w_sw_j1 >= 13'(w_sw_blk)) || (r_sj == IW'(MPB - 1));
    assign w_sw_done   = w_sw_last_j && (r_sb == SBW'(NB - 1));

    // ---------------- request decode ----------------
    scfl_decode #(
        .NB (NB)
    ) u_dec (
        .i_base     (r_lb),
        .i_count    (r_lc),
        .i_end      (r_end),
        .i_hvalid   (r_hv),
        .i_old_addr (r_old_addr),
        .i_new_size (r_new_size),
        .o_dec      (w_dec)
    );

    logic                        w_new;
    logic                        w_outside;
    logic                        w_pop;
    logic                        w_push;
    logic [scfl_pkg::BANK_W-1:0] w_pb;
    logic [31:0]                 w_pop_addr;
    logic [2:0]                  w_act;
    logic [31:0]                 w_addr;
    logic [31:0]                 w_len;
    logic [scfl_pkg::BANK_W-1:0] w_bank;

    assign w_new     = (r_old_size == 32'd0) && (r_new_size != 32'd0);
    assign w_outside = r_old_ext || (r_old_addr >= r_pos);
    assign w_pop_addr = r_start[SBW'(w_pb)]
                      + (32'(r_head[SBW'(w_pb)]) << (5'(r_lb) + 5'(w_pb)));

    always_comb begin
        w_pop  = 1'b0;
        w_push = 1'b0;
        w_pb   = w_dec.up_bank;
        w_act  = scfl_pkg::ACT_KEEP;
        w_addr = r_old_addr;
        w_len  = 32'd0;
        w_bank = w_dec.oslot;
        if (w_new) begin
            // fresh allocation from the size slot upward
            w_pop  = w_dec.up_found;
            w_act  = w_dec.up_found ? scfl_pkg::ACT_FRESH : scfl_pkg::ACT_FORWARD;
            w_addr = w_dec.up_found ? w_pop_addr : 32'd0;
            w_bank = w_dec.up_found ? w_dec.up_bank : scfl_pkg::NO_BANK;
        end else if (w_outside) begin
            w_act  = scfl_pkg::ACT_FORWARD;
            w_bank = scfl_pkg::NO_BANK;
        end else if (r_new_size == 32'd0) begin
            w_push = 1'b1;
            w_act  = scfl_pkg::ACT_FREED;
            w_bank = scfl_pkg::NO_BANK;
        end else if (w_dec.nslot == w_dec.oslot) begin
            w_act = scfl_pkg::ACT_KEEP;
        end else if (r_old_size < r_new_size) begin
            // grow: move inside the arena, else the host allocates outside
            w_pop  = w_dec.up_found;
            w_push = w_dec.up_found;
            w_len  = r_old_size;
            w_act  = w_dec.up_found ? scfl_pkg::ACT_MOVED : scfl_pkg::ACT_EXT_MOVE;
            w_addr = w_dec.up_found ? w_pop_addr : r_old_addr;
            w_bank = w_dec.up_found ? w_dec.up_bank : scfl_pkg::NO_BANK;
        end else begin
            // shrink: take a smaller block only if one is free
            w_pb   = w_dec.dn_bank;
            w_pop  = w_dec.dn_found;
            w_push = w_dec.dn_found;
            if (w_dec.dn_found) begin
                w_act  = scfl_pkg::ACT_MOVED;
                w_addr = w_pop_addr;
                w_len  = r_new_size;
                w_bank = w_dec.dn_bank;
            end
        end
    end

    // push of the old block into its own bank
    logic [31:0] w_push_idx;
    assign w_push_idx = (r_old_addr - r_start[SBW'(w_dec.oslot)]) >> (5'(r_lb) + 5'(w_dec.oslot));

    // ---------------- link memory ----------------
    scfl_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            scfl_pkg::ST_IDLE:  if (w_in_acc) n_state = s_axis_tuser[0] ? scfl_pkg::ST_LATCH
                                                                       : scfl_pkg::ST_DEC;
            scfl_pkg::ST_LATCH: n_state = scfl_pkg::ST_SWEEP;
            scfl_pkg::ST_SWEEP: if (w_sw_done) n_state = r_reply ? scfl_pkg::ST_DONE
                                                                  : scfl_pkg::ST_IDLE;
            scfl_pkg::ST_DEC:   n_state = w_pop  ? scfl_pkg::ST_POP :
                                          w_push ? scfl_pkg::ST_PUSH : scfl_pkg::ST_DONE;
            scfl_pkg::ST_POP:   n_state = r_do_push ? scfl_pkg::ST_PUSH : scfl_pkg::ST_DONE;
            scfl_pkg::ST_PUSH:  n_state = scfl_pkg::ST_DONE;
            scfl_pkg::ST_DONE:  if (w_load_out) n_state = scfl_pkg::ST_IDLE;
            default:            n_state = scfl_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_waddr   = AW'(r_sb) * AW'(MPB) + AW'(r_sj);
        w_mem_wdata   = {w_sw_j1 < 13'(w_sw_blk), w_sw_j1[scfl_pkg::LINK_W-1:0]};
        w_mem_re      = 1'b0;
        w_mem_raddr   = AW'(SBW'(w_pb)) * AW'(MPB) + AW'(r_head[SBW'(w_pb)][IW-1:0]);
        case (r_state)
            scfl_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            scfl_pkg::ST_SWEEP: w_mem_we = 1'b1;
            scfl_pkg::ST_DEC:   w_mem_re = w_pop;
            scfl_pkg::ST_PUSH: begin
                // old block links to the current head of its bank
                w_mem_we    = 1'b1;
                w_mem_waddr = AW'(SBW'(w_dec.oslot)) * AW'(MPB) + AW'(w_push_idx[IW-1:0]);
                w_mem_wdata = {r_hv[SBW'(w_dec.oslot)], r_head[SBW'(w_dec.oslot)]};
            end
            scfl_pkg::ST_DONE:  w_load_out = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scfl_pkg::ST_LATCH;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
            r_hv        <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_reply <= s_axis_tuser[0];
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == scfl_pkg::ST_SWEEP && r_sj == '0) begin
                r_hv[r_sb] <= (w_sw_blk != 9'd0);
            end
            if (r_state == scfl_pkg::ST_POP) begin
                r_hv[SBW'(r_pop_bank)] <= w_mem_rdata[DW-1];
            end
            if (r_state == scfl_pkg::ST_PUSH) begin
                r_hv[SBW'(w_dec.oslot)] <= 1'b1;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_old_ext  <= s_axis_tuser[1];
            r_old_addr <= s_axis_tdata[31:0];
            r_old_size <= s_axis_tdata[63:32];
            r_new_size <= s_axis_tdata[95:64];
        end
        case (r_state)
            scfl_pkg::ST_LATCH: begin
                r_lb  <= w_lb;
                r_lc  <= w_lc;
                r_pos <= 32'd0;
                r_sb  <= '0;
                r_sj  <= '0;
                for (int i = 0; i < NB; i++) begin
                    r_lat_blk[i] <= w_blk[i];
                end
                // reformat reply
                r_res_action <= scfl_pkg::ACT_FREED;
                r_res_addr   <= 32'd0;
                r_res_len    <= 32'd0;
                r_res_bank   <= scfl_pkg::NO_BANK;
            end
            scfl_pkg::ST_SWEEP: begin
                if (r_sj == '0) begin
                    r_start[r_sb] <= r_pos;
                    r_end[r_sb]   <= r_pos + w_sw_len;
                    r_pos         <= r_pos + w_sw_len;
                    r_head[r_sb]  <= '0;
                end
                if (w_sw_last_j) begin
                    r_sj <= '0;
                    if (!w_sw_done) r_sb <= r_sb + 1'b1;
                end else begin
                    r_sj <= r_sj + 1'b1;
                end
            end
            scfl_pkg::ST_DEC: begin
                r_res_action <= w_act;
                r_res_addr   <= w_addr;
                r_res_len    <= w_len;
                r_res_bank   <= w_bank;
                r_do_push    <= w_push;
                r_pop_bank   <= w_pb;
            end
            scfl_pkg::ST_POP: begin
                r_head[SBW'(r_pop_bank)] <= w_mem_rdata[scfl_pkg::LINK_W-1:0];
            end
            scfl_pkg::ST_PUSH: begin
                r_head[SBW'(w_dec.oslot)] <= w_push_idx[scfl_pkg::LINK_W-1:0];
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_out_action <= r_res_action;
            r_out_addr   <= r_res_addr;
            r_out_len    <= r_res_len;
            r_out_bank   <= r_res_bank;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_bank, r_out_len, r_out_addr};
    assign m_axis_tuser  = r_out_action;

endmodule

// ===== design/scfl_checker.sv =====
module scfl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // held word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // granted blocks name a real bank
    a_grant_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == scfl_pkg::ACT_FRESH ||
                          m_axis_tuser == scfl_pkg::ACT_MOVED)
        |-> m_axis_tdata[66:64] != scfl_pkg::NO_BANK)
        else $error("granted block without bank");

    // freed, forwarded and external-move actions carry no bank
    a_no_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == scfl_pkg::ACT_FREED ||
                          m_axis_tuser == scfl_pkg::ACT_FORWARD ||
                          m_axis_tuser == scfl_pkg::ACT_EXT_MOVE)
        |-> m_axis_tdata[66:64] == scfl_pkg::NO_BANK)
        else $error("bank given with non-grant action");

    // fresh blocks need no copy
    a_fresh_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == scfl_pkg::ACT_FRESH |-> m_axis_tdata[63:32] == 32'd0)
        else $error("copy length on fresh block");

endmodule

bind size_class_free_list_allocator scfl_checker u_scfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/scfl_checker.sv =====
module scfl_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBANK  = 6;
    localparam int NBLK   = 256;
    localparam int LINK_N = NBANK * NBLK;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] addr;
        logic [31:0] len;
        logic [2:0]  bank;
    } t_grant;

    logic [31:0]     cfg [8];
    logic [11:0]     link [LINK_N];
    bit              link_ok [LINK_N];
    logic [11:0]     head [NBANK];
    bit              head_ok [NBANK];
    int unsigned     lat_base;
    int unsigned     lat_banks;
    longint unsigned b_start [NBANK];
    longint unsigned b_end [NBANK];
    longint unsigned arena_end;
    t_grant          grant_q [$];
    int              fails = 0;

    // latch the layout and chain every bank in address order
    function automatic void relayout();
        int unsigned     b;
        int unsigned     n;
        int unsigned     blocks;
        longint unsigned pos;
        pos = 0;
        b = cfg[scfl_pkg::REG_BASE];
        if (b < 3) b = 3;
        if (b > 12) b = 12;
        n = cfg[scfl_pkg::REG_COUNT];
        if (n < 1) n = 1;
        if (n > NBANK) n = NBANK;
        lat_base = b;
        lat_banks = n;
        for (int i = 0; i < NBANK; i++) begin
            blocks = 0;
            if (i < n) begin
                blocks = cfg[scfl_pkg::REG_BLK0 + i];
                if (blocks < 1) blocks = 1;
                if (blocks > NBLK) blocks = NBLK;
            end
            b_start[i] = pos;
            pos += longint'(blocks) << (b + i);
            b_end[i] = pos;
            for (int j = 0; j < blocks; j++) begin
                link[i*NBLK + j] = 12'(j + 1);
                link_ok[i*NBLK + j] = (j + 1 < blocks);
            end
            head[i] = '0;
            head_ok[i] = (blocks != 0);
        end
        arena_end = pos;
    endfunction

    function automatic int size_bank(logic [31:0] sz);
        longint unsigned cap;
        int s;
        s = 0;
        cap = longint'(1) << lat_base;
        if (longint'(sz) > (longint'(1) << (lat_base + lat_banks - 1))) return lat_banks;
        while (longint'(sz) > cap) begin
            s++;
            cap <<= 1;
        end
        return s;
    endfunction

    function automatic int addr_bank(logic [31:0] a);
        int s;
        s = 0;
        while (s + 1 < lat_banks && longint'(a) >= b_end[s]) s++;
        return s;
    endfunction

    function automatic bit take_block(int first, int last, output longint unsigned a,
                                      output int bk);
        int k;
        a = 0;
        bk = int'(scfl_pkg::NO_BANK);
        for (int i = first; i < last && i < NBANK; i++) begin
            if (head_ok[i]) begin
                k = i*NBLK + (head[i] % NBLK);
                a = b_start[i] + (longint'(head[i]) << (lat_base + i));
                bk = i;
                head[i] = link[k];
                head_ok[i] = link_ok[k];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void return_block(logic [31:0] a);
        int s;
        int k;
        longint unsigned idx;
        s = addr_bank(a);
        idx = (longint'(a) - b_start[s]) >> (lat_base + s);
        k = s*NBLK + int'(idx % NBLK);
        link[k] = head[s];
        link_ok[k] = head_ok[s];
        head[s] = idx[11:0];
        head_ok[s] = 1'b1;
    endfunction

    function automatic t_grant mk(logic [2:0] act, longint unsigned a, logic [31:0] len,
                                  int bk);
        t_grant g;
        g.act = act;
        g.addr = a[31:0];
        g.len = len;
        g.bank = 3'(bk);
        return g;
    endfunction

    function automatic t_grant predict_grant(bit mode, bit ext, logic [31:0] oa,
                                             logic [31:0] os, logic [31:0] ns);
        int nb;
        int ob;
        int bk;
        longint unsigned a;
        if (mode) begin
            relayout();
            return mk(scfl_pkg::ACT_FREED, 0, 0, int'(scfl_pkg::NO_BANK));
        end
        nb = size_bank(ns);
        if (os == 0 && ns != 0) begin
            if (take_block(nb, lat_banks, a, bk)) return mk(scfl_pkg::ACT_FRESH, a, 0, bk);
            return mk(scfl_pkg::ACT_FORWARD, 0, 0, int'(scfl_pkg::NO_BANK));
        end
        if (ext || longint'(oa) >= arena_end)
            return mk(scfl_pkg::ACT_FORWARD, oa, 0, int'(scfl_pkg::NO_BANK));
        if (ns == 0) begin
            return_block(oa);
            return mk(scfl_pkg::ACT_FREED, oa, 0, int'(scfl_pkg::NO_BANK));
        end
        ob = addr_bank(oa);
        if (nb == ob) return mk(scfl_pkg::ACT_KEEP, oa, 0, ob);
        if (os < ns) begin
            if (take_block(nb, lat_banks, a, bk)) begin
                return_block(oa);
                return mk(scfl_pkg::ACT_MOVED, a, os, bk);
            end
            return mk(scfl_pkg::ACT_EXT_MOVE, oa, os, int'(scfl_pkg::NO_BANK));
        end
        if (take_block(nb, ob, a, bk)) begin
            return_block(oa);
            return mk(scfl_pkg::ACT_MOVED, a, ns, bk);
        end
        return mk(scfl_pkg::ACT_KEEP, oa, 0, ob);
    endfunction

    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        if (!i_rst_n) begin
            cfg[scfl_pkg::REG_BASE] = 4;
            cfg[scfl_pkg::REG_COUNT] = 6;
            for (int i = 0; i < NBANK; i++) cfg[scfl_pkg::REG_BLK0 + i] = 64;
            relayout();
            grant_q.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                cfg[paddr[4:2]] = pwdata & ((paddr[4:2] == scfl_pkg::REG_BASE) ? 32'hF :
                                  (paddr[4:2] == scfl_pkg::REG_COUNT) ? 32'h7 : 32'h1FF);
            if (s_axis_tvalid && s_axis_tready)
                grant_q.push_back(predict_grant(s_axis_tuser[0], s_axis_tuser[1],
                                  s_axis_tdata[31:0], s_axis_tdata[63:32],
                                  s_axis_tdata[95:64]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = mk(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                         int'(m_axis_tdata[66:64]));
                if (grant_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected word: act %0d addr %h len %h bank %0d",
                                 got.act, got.addr, got.len, got.bank);
                    fails++;
                end else begin
                    want = grant_q.pop_front();
                    if (got != want) begin
                        if (fails < 10)
                            $display({"mismatch: exp act %0d addr %h len %h bank %0d,",
                                      " got act %0d addr %h len %h bank %0d"},
                                     want.act, want.addr, want.len, want.bank,
                                     got.act, got.addr, got.len, got.bank);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= grant_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // room for several reformat sweeps per phase plus a long receiver hold
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // old_addr [31:0], old_size [63:32], new_size [95:64]
    logic [95:0] s_axis_tdata = '0;
    // mode [0], old_external [1]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // block_addr [31:0], copy_len [63:32], bank [66:64], zero fill [71:67]
    logic [71:0] m_axis_tdata;
    // action [2:0]
    logic [2:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // shadow of the registers and of the layout latched at the last reformat
    logic [31:0]     sh_cfg [8];
    int unsigned     sh_base;
    int unsigned     sh_banks;
    int unsigned     sh_blocks [6];
    longint unsigned sh_start [6];
    longint unsigned sh_end;

    bit  valid_hi = 1'b0;
    int  burst_left = 0;
    int  hold_req = 0;
    int  hold_cnt = 0;
    int  rx_phase = 0;
    int  cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    size_class_free_list_allocator u_dut (.*);

    scfl_scoreboard u_check (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: a long hold on request, otherwise a stall pattern chosen by bits
    // [8:7] of a phase counter: always ready, mostly ready, square wave and coin flip
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (hold_req != 0) begin
            hold_req = 0;
            hold_cnt = 400;
            m_axis_tready <= 1'b0;
        end else begin
            rx_phase++;
            case (rx_phase[8:7])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= rx_phase[2];
                default: m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // mirror the saturation the block applies when it latches the layout
    function automatic void latch_layout();
        longint unsigned pos;
        logic [31:0]     cb;
        logic [31:0]     cc;
        pos = 0;
        cb = sh_cfg[scfl_pkg::REG_BASE];
        cc = sh_cfg[scfl_pkg::REG_COUNT];
        sh_base = (cb < 3) ? 3 : (cb > 12) ? 12 : cb;
        sh_banks = (cc < 1) ? 1 : (cc > 6) ? 6 : cc;
        for (int i = 0; i < 6; i++) begin
            sh_blocks[i] = 0;
            if (i < sh_banks)
                sh_blocks[i] = (sh_cfg[scfl_pkg::REG_BLK0 + i] < 1) ? 1 :
                               (sh_cfg[scfl_pkg::REG_BLK0 + i] > 256) ? 256 :
                               sh_cfg[scfl_pkg::REG_BLK0 + i];
            sh_start[i] = pos;
            pos += longint'(sh_blocks[i]) << (sh_base + i);
        end
        sh_end = pos;
    endfunction

    // offer one word, hold it until taken, then maybe close the burst
    task automatic send_word(bit mode, bit ext, logic [31:0] oa, logic [31:0] os,
                             logic [31:0] ns);
        if (mode) latch_layout();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ns, os, oa};
        s_axis_tuser <= {ext, mode};
        valid_hi = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            valid_hi = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        if (valid_hi) begin
            s_axis_tvalid <= 1'b0;
            valid_hi = 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        sh_cfg[idx] = val;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        int unsigned e;
        if ($urandom_range(0, 9) == 0) return $urandom;
        e = $urandom_range(0, sh_banks - 1);
        return $urandom_range(1, 1 << (sh_base + e));
    endfunction

    // a block start inside the region, now and then off its alignment
    function automatic logic [31:0] pick_block();
        int unsigned b;
        longint unsigned a;
        b = $urandom_range(0, sh_banks - 1);
        a = sh_start[b] + (longint'($urandom_range(0, sh_blocks[b] - 1)) << (sh_base + b));
        if ($urandom_range(0, 9) == 0) a += $urandom_range(0, (1 << (sh_base + b)) - 1);
        return a[31:0];
    endfunction

    task automatic random_words(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) send_word(1'b0, $urandom_range(0, 1), $urandom, 0, pick_size());
            else if (r < 50) send_word(1'b0, 1'b0, pick_block(), pick_size(), 0);
            else if (r < 82) send_word(1'b0, 1'b0, pick_block(), pick_size(), pick_size());
            else if (r < 87) send_word(1'b0, 1'b1, $urandom, pick_size(), pick_size());
            else if (r < 92) send_word(1'b0, 1'b0, sh_end[31:0] + $urandom_range(0, 4095),
                                       pick_size(), pick_size());
            else if (r < 94) send_word(1'b1, $urandom_range(0, 1), $urandom, $urandom, $urandom);
            else send_word(1'b0, $urandom_range(0, 1), $urandom, $urandom, $urandom);
        end
    endtask

    // write a full register set, then reformat so it takes effect
    task automatic set_layout(logic [31:0] b, logic [31:0] n, logic [31:0] blk [6]);
        drain();
        reg_write(scfl_pkg::REG_BASE, b);
        reg_write(scfl_pkg::REG_COUNT, n);
        for (int i = 0; i < 6; i++) reg_write(scfl_pkg::REG_BLK0 + 3'(i), blk[i]);
        send_word(1'b1, 1'b0, 0, 0, 0);
    endtask

    initial begin
        logic [31:0] blk [6];
        sh_cfg[scfl_pkg::REG_BASE] = 4;
        sh_cfg[scfl_pkg::REG_COUNT] = 6;
        for (int i = 0; i < 6; i++) sh_cfg[scfl_pkg::REG_BLK0 + i] = 64;
        latch_layout();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset layout: 16-byte base, six banks of 64
        send_word(1'b0, 1'b0, 0, 0, 1);                   // smallest request
        send_word(1'b0, 1'b0, 0, 0, 16);                  // exactly one base block
        send_word(1'b0, 1'b0, 0, 0, 17);                  // spills to bank 1
        send_word(1'b0, 1'b0, 0, 0, 512);                 // largest block
        send_word(1'b0, 1'b0, 0, 0, 513);                 // too big, forward
        send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        send_word(1'b0, 1'b0, 0, 0, 0);                   // zero sizes: free path
        send_word(1'b0, 1'b1, 32'h1234, 8, 20);           // old pointer external
        send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 4, 4);       // past region end
        send_word(1'b0, 1'b0, 21, 10, 0);                 // free by inner address
        send_word(1'b0, 1'b0, 0, 4, 10);                  // same bank, keep
        send_word(1'b0, 1'b0, 0, 8, 100);                 // grow
        send_word(1'b0, 1'b0, 7168, 100, 3);              // shrink from bank 3
        send_word(1'b0, 1'b0, 32, 16, 0);                 // free twice
        send_word(1'b0, 1'b0, 32, 16, 0);
        send_word(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        random_words(40);
        hold_req = 1;                                     // long receiver hold
        random_words(70);

        // smallest layout, written below the legal range so it saturates
        for (int i = 0; i < 6; i++) blk[i] = 0;
        set_layout(0, 0, blk);
        random_words(80);

        // largest layout, written above the legal range
        for (int i = 0; i < 6; i++) blk[i] = 511;
        set_layout(15, 7, blk);
        random_words(80);

        repeat (2) begin
            for (int i = 0; i < 6; i++)
                blk[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 511) :
                         $urandom_range(1, 12);
            set_layout($urandom_range(0, 15), $urandom_range(0, 7), blk);
            random_words(90);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
